>>> hdl/async_character_deframer_top_defines.svh
// Assertion macros used by the deframer output queue.
`ifndef ASYNC_CHARACTER_DEFRAMER_TOP_DEFINES_SVH
`define ASYNC_CHARACTER_DEFRAMER_TOP_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define ACD_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ACD_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

>>> hdl/acd_pkg.sv
// Types, codes and helpers shared by the character deframer modules.
package acd_pkg;

  localparam int LINE_BITS = 8;
  localparam int WORD_BITS = 8;
  localparam int OUT_INDEX_BITS = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_BITS = 2;
  localparam int FIFO_CNT_BITS = 3;

  // Register indexes (paddr[2])
  localparam logic REG_DATA_BITS = 1'b0;
  localparam logic REG_PARITY_MODE = 1'b1;

  localparam logic [3:0] DATA_BITS_RESET = 4'd8;
  localparam logic [3:0] WIDTH_MIN = 4'd5;
  localparam logic [3:0] WIDTH_MAX = 4'd8;

  typedef enum logic [1:0] {
    PAR_NONE = 2'd0,
    PAR_EVEN = 2'd1,
    PAR_ODD  = 2'd2
  } parity_mode_t;

  // Deframer state carried from one bit to the next
  typedef struct packed {
    logic                 in_char;
    logic [3:0]           pos;
    logic [WORD_BITS-1:0] word;
    logic                 par;
    logic                 await_par;
  } lane_state_t;

  localparam lane_state_t LANE_CLEAR = '{
    in_char: 1'b0, pos: 4'd0, word: '0, par: 1'b0, await_par: 1'b0
  };

  // What one bit lane found
  typedef struct packed {
    logic                 emit;
    logic                 err;
    logic [WORD_BITS-1:0] word;
  } lane_out_t;

  // One result word
  typedef struct packed {
    logic [WORD_BITS-1:0]      data_word;
    logic                      parity_error;
    logic [OUT_INDEX_BITS-1:0] char_index;
    logic                      last;
  } result_t;

  // Clamp the configured data width to 5..8
  function automatic logic [3:0] width_in_effect(input logic [3:0] data_bits);
    logic [3:0] w;
    w = data_bits;
    if (data_bits < WIDTH_MIN) w = WIDTH_MIN;
    if (data_bits > WIDTH_MAX) w = WIDTH_MAX;
    return w;
  endfunction

endpackage

>>> hdl/acd_lane.sv
// One bit lane: advances the deframer state by one line bit.
module acd_lane (
  input  logic                bit_in,
  input  logic [3:0]          width,
  input  logic [1:0]          parity_mode,
  input  acd_pkg::lane_state_t state_in,
  output acd_pkg::lane_state_t state_out,
  output acd_pkg::lane_out_t   found
);

  logic [3:0] pos_inc;
  logic       par_on;

  assign pos_inc = state_in.pos + 4'd1;
  assign par_on  = (parity_mode == acd_pkg::PAR_EVEN) || (parity_mode == acd_pkg::PAR_ODD);

  // Step the character state machine by one bit
  always_comb begin
    state_out  = state_in;
    found.emit = 1'b0;
    found.err  = 1'b0;
    found.word = state_in.word;
    if (state_in.await_par) begin
      // take the parity bit and finish the character
      found.emit = 1'b1;
      case (parity_mode)
        acd_pkg::PAR_EVEN: found.err = state_in.par ^ bit_in;
        acd_pkg::PAR_ODD:  found.err = ~(state_in.par ^ bit_in);
        default:           found.err = 1'b0;
      endcase
      state_out = acd_pkg::LANE_CLEAR;
    end else if (!state_in.in_char) begin
      // hunt for the start bit; ones are stop or idle bits
      if (!bit_in) state_out.in_char = 1'b1;
    end else begin
      // gather a data bit
      if (bit_in && (state_in.pos < 4'd8)) state_out.word[state_in.pos[2:0]] = 1'b1;
      state_out.par = state_in.par ^ bit_in;
      state_out.pos = pos_inc;
      if (pos_inc >= width) begin
        if (par_on) begin
          state_out.in_char   = 1'b0;
          state_out.pos       = 4'd0;
          state_out.await_par = 1'b1;
        end else begin
          found.emit = 1'b1;
          found.word = state_out.word;
          state_out  = acd_pkg::LANE_CLEAR;
        end
      end
    end
  end

endmodule

>>> hdl/acd_merge.sv
// Merge stage: collects up to two finished characters from the bit lanes.
module acd_merge #(
  parameter int INDEX_BITS = 16
) (
  input  acd_pkg::lane_out_t  found [acd_pkg::LINE_BITS],
  input  logic [INDEX_BITS-1:0] count,
  output acd_pkg::result_t    res0,
  output acd_pkg::result_t    res1,
  output logic [1:0]          res_n
);

  logic [INDEX_BITS-1:0] count_inc;
  logic [1:0]            n;
  acd_pkg::lane_out_t    f0;
  acd_pkg::lane_out_t    f1;

  assign count_inc = count + INDEX_BITS'(1);

  // Pick the first and second lanes that finished a character
  always_comb begin
    n  = 2'd0;
    f0 = '0;
    f1 = '0;
    for (int j = 0; j < acd_pkg::LINE_BITS; j++) begin
      if (found[j].emit) begin
        if (n == 2'd0) begin
          f0 = found[j];
          n  = 2'd1;
        end else if (n == 2'd1) begin
          f1 = found[j];
          n  = 2'd2;
        end
      end
    end
  end

  // Build the result words; the final one of the byte carries last
  always_comb begin
    res0.data_word    = f0.word;
    res0.parity_error = f0.err;
    res0.char_index   = acd_pkg::OUT_INDEX_BITS'(32'(count));
    res0.last         = (n == 2'd1);
    res1.data_word    = f1.word;
    res1.parity_error = f1.err;
    res1.char_index   = acd_pkg::OUT_INDEX_BITS'(32'(count_inc));
    res1.last         = 1'b1;
  end

  assign res_n = n;

endmodule

>>> hdl/acd_out_fifo.sv
// Output queue: takes up to two result words a cycle, hands out one.
`include "async_character_deframer_top_defines.svh"

module acd_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_n,
  input  acd_pkg::result_t push0,
  input  acd_pkg::result_t push1,
  output logic             room,
  output logic             pop_valid,
  input  logic             pop_ready,
  output acd_pkg::result_t head
);

  acd_pkg::result_t mem [acd_pkg::FIFO_DEPTH];
  logic [acd_pkg::FIFO_PTR_BITS-1:0] wr;
  logic [acd_pkg::FIFO_PTR_BITS-1:0] rd;
  logic [acd_pkg::FIFO_CNT_BITS-1:0] count;
  logic [acd_pkg::FIFO_CNT_BITS-1:0] count_next;
  logic                              pop;
  logic [acd_pkg::FIFO_PTR_BITS-1:0] wr_inc;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count != '0);
  assign room      = (count <= acd_pkg::FIFO_CNT_BITS'(acd_pkg::FIFO_DEPTH - 2));
  assign head      = mem[rd];
  assign wr_inc    = wr + acd_pkg::FIFO_PTR_BITS'(1);
  assign count_next = count + acd_pkg::FIFO_CNT_BITS'(push_n)
                    - acd_pkg::FIFO_CNT_BITS'(pop);

  // Store incoming words
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr] <= push0;
    if (push_n == 2'd2) mem[wr_inc] <= push1;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + acd_pkg::FIFO_PTR_BITS'(push_n);
      rd    <= rd + acd_pkg::FIFO_PTR_BITS'(pop);
      count <= count_next;
    end
  end

  `ACD_ASSERT(a_fill_bound, clk, rst, count <= acd_pkg::FIFO_CNT_BITS'(acd_pkg::FIFO_DEPTH), "output queue overfilled")
  `ACD_ASSERT(a_push_room, clk, rst, (push_n != 2'd0) |-> room, "word pushed without room")
  `ACD_ASSERT(a_pair_whole, clk, rst, (pop_valid && !head.last) |-> (count >= acd_pkg::FIFO_CNT_BITS'(2)), "first word of a pair queued without its partner")

endmodule

>>> hdl/async_character_deframer_top.sv
// Top level of the asynchronous character deframer with parity check.
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+------------------------------------
//  input    | in_valid / in_ready              | line_byte, block_end
//  output   | out_valid / out_ready            | data_word, parity_error, char_index, last
//  config   | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// A byte is taken at once: eight chained bit lanes walk it and the merge
// stage writes up to two result words into a four-word output queue.
// in_ready is high while the queue holds two words or fewer, so a byte can
// enter every cycle while results drain; the one-word-a-cycle output port
// sets the sustained rate when bytes finish two characters.
// Synchronous reset clears the deframer state, the index and the queue.
module async_character_deframer_top #(
  parameter int INDEX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  line_byte,
  input  logic        block_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_word,
  output logic        parity_error,
  output logic [15:0] char_index,
  output logic        last
);

  logic [3:0]            data_bits;
  logic [1:0]            parity_mode;
  logic [3:0]            width;
  logic                  cfg_write;
  logic                  accept;
  acd_pkg::lane_state_t  state;
  acd_pkg::lane_state_t  chain [acd_pkg::LINE_BITS + 1];
  acd_pkg::lane_out_t    found [acd_pkg::LINE_BITS];
  logic [INDEX_BITS-1:0] count;
  logic [INDEX_BITS-1:0] count_next;
  acd_pkg::result_t      res0;
  acd_pkg::result_t      res1;
  logic [1:0]            res_n;
  acd_pkg::result_t      head;
  logic                  room;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_bits   <= acd_pkg::DATA_BITS_RESET;
      parity_mode <= acd_pkg::PAR_NONE;
    end else if (cfg_write) begin
      case (paddr[2])
        acd_pkg::REG_DATA_BITS:   data_bits   <= pwdata[3:0];
        acd_pkg::REG_PARITY_MODE: parity_mode <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      acd_pkg::REG_DATA_BITS:   prdata = {28'd0, data_bits};
      acd_pkg::REG_PARITY_MODE: prdata = {30'd0, parity_mode};
      default:                  prdata = 32'd0;
    endcase
  end

  assign width  = acd_pkg::width_in_effect(data_bits);
  assign accept = in_valid && in_ready;

  // Chain the bit lanes, earliest bit first
  assign chain[0] = state;

  for (genvar j = 0; j < acd_pkg::LINE_BITS; j++) begin : g_lane
    acd_lane u_lane (
      .bit_in      (line_byte[j]),
      .width       (width),
      .parity_mode (parity_mode),
      .state_in    (chain[j]),
      .state_out   (chain[j+1]),
      .found       (found[j])
    );
  end

  acd_merge #(
    .INDEX_BITS (INDEX_BITS)
  ) u_merge (
    .found (found),
    .count (count),
    .res0  (res0),
    .res1  (res1),
    .res_n (res_n)
  );

  // Hold deframer state and index; block end drops both
  assign count_next = count + INDEX_BITS'(res_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= acd_pkg::LANE_CLEAR;
      count <= '0;
    end else if (accept) begin
      if (block_end) begin
        state <= acd_pkg::LANE_CLEAR;
        count <= '0;
      end else begin
        state <= chain[acd_pkg::LINE_BITS];
        count <= count_next;
      end
    end
  end

  acd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (accept ? res_n : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .head      (head)
  );

  assign in_ready     = room;
  assign data_word    = head.data_word;
  assign parity_error = head.parity_error;
  assign char_index   = head.char_index;
  assign last         = head.last;

endmodule
